// File: sv/bfq_pkg.sv
// ---------------------------------------------------------------------------
// bfq_pkg: shared types and constants for the bounded FIFO queue
// Sizes, operation and status codes, and the command and status bundles
// that join the queue controller and its datapath.
// ---------------------------------------------------------------------------
package bfq_pkg;

    // Storage depth and derived widths
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int WORD_W  = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_TRAVERSE = 2'd2,
        OP_CLEAR    = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_PUSHED        = 3'd0,
        ST_FULL_REFUSED  = 3'd1,
        ST_POPPED        = 3'd2,
        ST_EMPTY_REFUSED = 3'd3,
        ST_TRAV_WORD     = 3'd4,
        ST_TRAV_EMPTY    = 3'd5,
        ST_CLEARED       = 3'd6
    } status_t;

    // Source of the out_word field
    typedef enum logic [1:0] {
        WSEL_ZERO = 2'd0,
        WSEL_POP  = 2'd1,
        WSEL_RD   = 2'd2
    } wsel_t;

    // Controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    do_push;
        logic    do_pop;
        logic    do_clear;
        logic    idx_inc;
        logic    front_load;
        logic    emit;
        status_t code;
        logic    last;
        wsel_t   wsel;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic    in_fire;
        opcode_t op;
        logic    empty;
        logic    full;
        logic    out_free;
        logic    idx_last;
    } stat_t;

    // Circular index add: both operands below DEPTH
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ADDR_W+1)'(DEPTH))
            s = s - (ADDR_W+1)'(DEPTH);
        return s[ADDR_W-1:0];
    endfunction

endpackage

// File: sv/bfq_if.sv
// ---------------------------------------------------------------------------
// bfq_if: request and response channels of the bounded FIFO queue
// Valid/ready channels; a word moves at a clock edge with both high.
// ---------------------------------------------------------------------------
interface bfq_req_if;
    logic                        valid;
    logic                        ready;
    logic [bfq_pkg::OP_W-1:0]    opcode;
    logic [bfq_pkg::WORD_W-1:0]  push_word;

    modport source (output valid, output opcode, output push_word, input ready);
    modport sink   (input valid, input opcode, input push_word, output ready);
endinterface

interface bfq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bfq_pkg::STAT_W-1:0]  status;
    logic [bfq_pkg::WORD_W-1:0]  out_word;
    logic                        last_flag;
    logic [bfq_pkg::COUNT_W-1:0] entry_count;
    logic                        empty_flag;
    logic                        full_flag;
    logic [bfq_pkg::WORD_W-1:0]  front_word;

    modport source (output valid, output status, output out_word, output last_flag,
                    output entry_count, output empty_flag, output full_flag,
                    output front_word, input ready);
    modport sink   (input valid, input status, input out_word, input last_flag,
                    input entry_count, input empty_flag, input full_flag,
                    input front_word, output ready);
endinterface

// File: sv/bfq_dpath.sv
// ---------------------------------------------------------------------------
// bfq_dpath: queue storage, pointers and output register
// Holds the word memory, head and count, a copy of the front word, the
// traverse index and the response register. Acts only on controller commands.
// ---------------------------------------------------------------------------
module bfq_dpath (
    input  logic              clk,
    input  logic              rst_n,
    bfq_req_if.sink           req,
    bfq_rsp_if.source         rsp,
    input  bfq_pkg::cmd_t     cmd,
    output bfq_pkg::stat_t    stat
);

    logic [bfq_pkg::WORD_W-1:0]  mem [bfq_pkg::DEPTH];
    logic [bfq_pkg::WORD_W-1:0]  rd_data_reg;

    logic [bfq_pkg::ADDR_W-1:0]  head_reg;
    logic [bfq_pkg::CNT_W-1:0]   count_reg;
    logic [bfq_pkg::WORD_W-1:0]  front_reg;
    logic [bfq_pkg::WORD_W-1:0]  pop_word_reg;
    bfq_pkg::opcode_t            op_reg;
    logic [bfq_pkg::WORD_W-1:0]  word_reg;
    logic [bfq_pkg::ADDR_W-1:0]  idx_reg;

    logic                        out_valid_reg;
    bfq_pkg::status_t            out_status_reg;
    logic [bfq_pkg::WORD_W-1:0]  out_word_reg;
    logic                        out_last_reg;
    logic [bfq_pkg::COUNT_W-1:0] out_count_reg;
    logic                        out_empty_reg;
    logic                        out_full_reg;
    logic [bfq_pkg::WORD_W-1:0]  out_front_reg;

    logic                        in_fire;
    logic                        empty;
    logic                        full;
    logic                        out_free;
    logic [bfq_pkg::ADDR_W-1:0]  wr_addr;
    logic [bfq_pkg::ADDR_W-1:0]  rd_off;
    logic [bfq_pkg::ADDR_W-1:0]  rd_addr;
    logic [bfq_pkg::WORD_W-1:0]  emit_word;

    // Handshake and status toward the controller
    assign req.ready = cmd.in_ready;
    assign in_fire   = req.valid & cmd.in_ready;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == bfq_pkg::CNT_W'(bfq_pkg::DEPTH));
    assign out_free  = ~out_valid_reg | rsp.ready;

    assign stat.in_fire  = in_fire;
    assign stat.op       = op_reg;
    assign stat.empty    = empty;
    assign stat.full     = full;
    assign stat.out_free = out_free;
    assign stat.idx_last = ((bfq_pkg::CNT_W'(idx_reg) + bfq_pkg::CNT_W'(1)) == count_reg);

    // Addresses: write at tail, read at head plus index (one ahead on step or pop)
    assign wr_addr = bfq_pkg::wrap_add(head_reg, bfq_pkg::ADDR_W'(count_reg));
    assign rd_off  = idx_reg + bfq_pkg::ADDR_W'(cmd.idx_inc | cmd.do_pop);
    assign rd_addr = bfq_pkg::wrap_add(head_reg, rd_off);

    // Word memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.do_push)
            mem[wr_addr] <= word_reg;
        rd_data_reg <= mem[rd_addr];
    end

    // Head and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.do_clear)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.do_push)
        begin
            count_reg <= count_reg + bfq_pkg::CNT_W'(1);
        end
        else if (cmd.do_pop)
        begin
            head_reg  <= bfq_pkg::wrap_add(head_reg, bfq_pkg::ADDR_W'(1));
            count_reg <= count_reg - bfq_pkg::CNT_W'(1);
        end
    end

    // Input latch, traverse index, front copy and popped word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= bfq_pkg::opcode_t'(req.opcode);
            word_reg <= req.push_word;
            idx_reg  <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + bfq_pkg::ADDR_W'(1);
        end

        if (cmd.do_push && empty)
            front_reg <= word_reg;
        else if (cmd.front_load)
            front_reg <= rd_data_reg;

        if (cmd.do_pop)
            pop_word_reg <= front_reg;
    end

    // Output word select
    always_comb
    begin
        case (cmd.wsel)
            bfq_pkg::WSEL_POP:  emit_word = pop_word_reg;
            bfq_pkg::WSEL_RD:   emit_word = rd_data_reg;
            default:            emit_word = '0;
        endcase
    end

    // Response register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // Response register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.code;
            out_word_reg   <= emit_word;
            out_last_reg   <= cmd.last;
            out_count_reg  <= bfq_pkg::COUNT_W'(count_reg);
            out_empty_reg  <= empty;
            out_full_reg   <= full;
            out_front_reg  <= empty ? '0 : front_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.out_word    = out_word_reg;
    assign rsp.last_flag   = out_last_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.empty_flag  = out_empty_reg;
    assign rsp.full_flag   = out_full_reg;
    assign rsp.front_word  = out_front_reg;

endmodule

// File: sv/bfq_ctrl.sv
// ---------------------------------------------------------------------------
// bfq_ctrl: queue operation sequencer
// Steps each accepted word through update, memory read (pop only) and
// response phases, and walks the stored words for a traverse.
// ---------------------------------------------------------------------------
module bfq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  bfq_pkg::stat_t    stat,
    output bfq_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_LOAD,
        S_EMIT,
        S_TRAV
    } state_t;

    state_t            state_reg;
    bfq_pkg::status_t  code_reg;
    bfq_pkg::wsel_t    wsel_reg;

    // Commands per state
    always_comb
    begin
        cmd      = '0;
        cmd.code = code_reg;
        cmd.wsel = bfq_pkg::WSEL_ZERO;
        cmd.last = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            S_EXEC:
            begin
                case (stat.op)
                    bfq_pkg::OP_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd.emit = stat.out_free;
                            cmd.code = bfq_pkg::ST_FULL_REFUSED;
                        end
                        else
                            cmd.do_push = 1'b1;
                    end
                    bfq_pkg::OP_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit = stat.out_free;
                            cmd.code = bfq_pkg::ST_EMPTY_REFUSED;
                        end
                        else
                            cmd.do_pop = 1'b1;
                    end
                    bfq_pkg::OP_TRAVERSE:
                    begin
                        // first read at head is issued here
                        if (stat.empty)
                        begin
                            cmd.emit = stat.out_free;
                            cmd.code = bfq_pkg::ST_TRAV_EMPTY;
                        end
                    end
                    default:
                    begin
                        cmd.do_clear = 1'b1;
                    end
                endcase
            end
            S_POP_LOAD:
            begin
                cmd.front_load = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit = stat.out_free;
                cmd.wsel = wsel_reg;
            end
            S_TRAV:
            begin
                cmd.emit    = stat.out_free;
                cmd.code    = bfq_pkg::ST_TRAV_WORD;
                cmd.wsel    = bfq_pkg::WSEL_RD;
                cmd.last    = stat.idx_last;
                cmd.idx_inc = stat.out_free & ~stat.idx_last;
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

    // State and pending response code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= bfq_pkg::ST_PUSHED;
            wsel_reg  <= bfq_pkg::WSEL_ZERO;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (stat.in_fire)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    case (stat.op)
                        bfq_pkg::OP_PUSH:
                        begin
                            if (!stat.full)
                            begin
                                code_reg  <= bfq_pkg::ST_PUSHED;
                                wsel_reg  <= bfq_pkg::WSEL_ZERO;
                                state_reg <= S_EMIT;
                            end
                            else if (stat.out_free)
                                state_reg <= S_IDLE;
                        end
                        bfq_pkg::OP_POP:
                        begin
                            if (!stat.empty)
                            begin
                                code_reg  <= bfq_pkg::ST_POPPED;
                                wsel_reg  <= bfq_pkg::WSEL_POP;
                                state_reg <= S_POP_LOAD;
                            end
                            else if (stat.out_free)
                                state_reg <= S_IDLE;
                        end
                        bfq_pkg::OP_TRAVERSE:
                        begin
                            if (!stat.empty)
                                state_reg <= S_TRAV;
                            else if (stat.out_free)
                                state_reg <= S_IDLE;
                        end
                        default:
                        begin
                            code_reg  <= bfq_pkg::ST_CLEARED;
                            wsel_reg  <= bfq_pkg::WSEL_ZERO;
                            state_reg <= S_EMIT;
                        end
                    endcase
                end
                S_POP_LOAD:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (stat.out_free)
                        state_reg <= S_IDLE;
                end
                S_TRAV:
                begin
                    if (stat.out_free && stat.idx_last)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/bounded_fifo_queue.sv
// ---------------------------------------------------------------------------
// bounded_fifo_queue: bounded FIFO of 32-bit words
// Push, pop, traverse and clear on a valid/ready request channel; one or
// more response words per request on a valid/ready response channel.
// ---------------------------------------------------------------------------
// Each request word is handled to completion before the next is taken.
// The sequencer takes a push or clear through its update and response
// states; a pop through update, a front reload from the single-read-port
// word memory with registered read data, and response; a refused push or
// pop or a traverse of an empty queue answers in the update state; and a
// traverse reads the head there, then returns one response word per cycle
// while the response side is ready. A finished response waits in an output
// register; the next request is accepted while it waits. Storage is not
// cleared after reset; only written entries are ever returned.
module bounded_fifo_queue (
    input  logic       clk,
    input  logic       rst_n,
    bfq_req_if.sink    req,
    bfq_rsp_if.source  rsp
);

    bfq_pkg::cmd_t   cmd;
    bfq_pkg::stat_t  stat;

    // Sequencer
    bfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Storage and response register
    bfq_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

// File: sim/bounded_fifo_queue_test.sv
// ---------------------------------------------------------------------------
// bounded_fifo_queue_test: self-checking bench for the bounded FIFO queue
// A short table of directed requests (empty and full refusals, extreme
// words, clear, a full-depth traverse) is followed by random push/pop/
// traverse/clear traffic that alternates between filling and draining.
// Every response word is checked field by field against a behavioral queue
// mirror or typed row, with random idle gaps on request and response sides.
// ---------------------------------------------------------------------------
module bounded_fifo_queue_test;

    localparam int RANDOM_ITEMS = 155;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TABLE_ROWS   = 25;

    // One response word as the bench sees it
    typedef struct packed {
        bfq_pkg::status_t             status;
        logic [bfq_pkg::WORD_W-1:0]   out_word;
        logic                         last;
        logic [bfq_pkg::COUNT_W-1:0]  count;
        logic                         empty;
        logic                         full;
        logic [bfq_pkg::WORD_W-1:0]   front;
    } queue_rsp_t;

    // One directed request; typed rows carry their own expected response
    typedef struct packed {
        bfq_pkg::opcode_t             op;
        logic [bfq_pkg::WORD_W-1:0]   word;
        logic                         typed;
        queue_rsp_t                   rsp;
    } stim_row_t;

    localparam queue_rsp_t RSP_NONE       = '0;
    localparam queue_rsp_t RSP_POP_EMPTY  =
        '{bfq_pkg::ST_EMPTY_REFUSED, 32'h0, 1'b1, 5'd0, 1'b1, 1'b0, 32'h0};
    localparam queue_rsp_t RSP_TRAV_EMPTY =
        '{bfq_pkg::ST_TRAV_EMPTY, 32'h0, 1'b1, 5'd0, 1'b1, 1'b0, 32'h0};
    localparam queue_rsp_t RSP_CLEARED    =
        '{bfq_pkg::ST_CLEARED, 32'h0, 1'b1, 5'd0, 1'b1, 1'b0, 32'h0};
    // Push into a full queue; front is the first word of the fill below
    localparam queue_rsp_t RSP_PUSH_FULL  =
        '{bfq_pkg::ST_FULL_REFUSED, 32'h0, 1'b1, 5'd16, 1'b0, 1'b1, 32'hFFFF_FFFF};

    localparam stim_row_t DIR_TABLE [TABLE_ROWS] = '{
        '{bfq_pkg::OP_POP,      32'h0000_0000, 1'b1, RSP_POP_EMPTY},
        '{bfq_pkg::OP_TRAVERSE, 32'h0000_0000, 1'b1, RSP_TRAV_EMPTY},
        '{bfq_pkg::OP_PUSH,     32'hFFFF_FFFF, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h0000_0000, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_TRAVERSE, 32'h0000_0000, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_POP,      32'h0000_0000, 1'b0, RSP_NONE},
        // clear with head off zero: refill must restart at slot zero
        '{bfq_pkg::OP_CLEAR,    32'hFFFF_FFFF, 1'b1, RSP_CLEARED},
        '{bfq_pkg::OP_PUSH,     32'hFFFF_FFFF, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h0000_0001, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h8000_0000, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h7FFF_FFFF, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h5555_5555, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'hAAAA_AAAA, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h0000_0000, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'hDEAD_BEEF, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h0F0F_0F0F, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'hF0F0_F0F0, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h1234_5678, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h8765_4321, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h00FF_00FF, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'hFF00_FF00, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'h3F80_0000, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'hBF80_0000, 1'b0, RSP_NONE},
        '{bfq_pkg::OP_PUSH,     32'hCAFE_F00D, 1'b1, RSP_PUSH_FULL},
        '{bfq_pkg::OP_TRAVERSE, 32'h0000_0000, 1'b0, RSP_NONE}
    };

    logic clk = 1'b0;
    logic rst_n;

    bfq_req_if req ();
    bfq_rsp_if rsp ();

    bounded_fifo_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Queue mirror
    logic [bfq_pkg::WORD_W-1:0] mirror_store [bfq_pkg::DEPTH];
    int                         mirror_head  = 0;
    int                         mirror_count = 0;

    queue_rsp_t pending_rsps [$];

    int  mismatches     = 0;
    int  req_count      = 0;
    int  rsp_seen       = 0;
    int  full_refusals  = 0;
    int  empty_refusals = 0;
    int  longest_trav   = 0;
    bit  steady         = 1'b0;

    // Mirror slot of the word at offset off from the head
    function automatic logic [bfq_pkg::ADDR_W-1:0] slot(input int off);
        return bfq_pkg::ADDR_W'((mirror_head + off) % bfq_pkg::DEPTH);
    endfunction

    // Response word built from the mirror's state after the operation
    function automatic queue_rsp_t snapshot(input bfq_pkg::status_t st,
                                            input logic [bfq_pkg::WORD_W-1:0] w,
                                            input logic last);
        queue_rsp_t r;
        r.status   = st;
        r.out_word = w;
        r.last     = last;
        r.count    = bfq_pkg::COUNT_W'(mirror_count);
        r.empty    = (mirror_count == 0);
        r.full     = (mirror_count == bfq_pkg::DEPTH);
        r.front    = (mirror_count == 0) ? '0 : mirror_store[slot(0)];
        return r;
    endfunction

    // Apply one request to the mirror; queue its responses when asked to
    function automatic void predict_responses(input bfq_pkg::opcode_t op,
                                              input logic [bfq_pkg::WORD_W-1:0] w,
                                              input bit keep);
        queue_rsp_t                 res [$];
        logic [bfq_pkg::WORD_W-1:0] popped;
        case (op)
            bfq_pkg::OP_PUSH:
                if (mirror_count == bfq_pkg::DEPTH) begin
                    full_refusals++;
                    res.push_back(snapshot(bfq_pkg::ST_FULL_REFUSED, '0, 1'b1));
                end
                else begin
                    mirror_store[slot(mirror_count)] = w;
                    mirror_count++;
                    res.push_back(snapshot(bfq_pkg::ST_PUSHED, '0, 1'b1));
                end
            bfq_pkg::OP_POP:
                if (mirror_count == 0) begin
                    empty_refusals++;
                    res.push_back(snapshot(bfq_pkg::ST_EMPTY_REFUSED, '0, 1'b1));
                end
                else begin
                    popped = mirror_store[slot(0)];
                    mirror_head = (mirror_head + 1) % bfq_pkg::DEPTH;
                    mirror_count--;
                    res.push_back(snapshot(bfq_pkg::ST_POPPED, popped, 1'b1));
                end
            bfq_pkg::OP_TRAVERSE:
                if (mirror_count == 0) begin
                    res.push_back(snapshot(bfq_pkg::ST_TRAV_EMPTY, '0, 1'b1));
                end
                else begin
                    if (mirror_count > longest_trav)
                        longest_trav = mirror_count;
                    for (int i = 0; i < mirror_count; i++)
                        res.push_back(snapshot(bfq_pkg::ST_TRAV_WORD,
                                               mirror_store[slot(i)],
                                               i == mirror_count - 1));
                end
            default:
                begin
                    mirror_count = 0;
                    mirror_head  = 0;
                    res.push_back(snapshot(bfq_pkg::ST_CLEARED, '0, 1'b1));
                end
        endcase
        if (keep)
            foreach (res[i])
                pending_rsps.push_back(res[i]);
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Drive one request word from a falling edge until it is taken
    task automatic send_request(input bfq_pkg::opcode_t op,
                                input logic [bfq_pkg::WORD_W-1:0] w,
                                input logic typed, input queue_rsp_t typed_rsp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.opcode    <= op;
        req.push_word <= w;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        req_count++;
        predict_responses(op, w, !typed);
        if (typed)
            pending_rsps.push_back(typed_rsp);
        @(negedge clk);
    endtask

    task automatic compare_field(input string field,
                                 input logic [bfq_pkg::WORD_W-1:0] want,
                                 input logic [bfq_pkg::WORD_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s differs on response %0d: expected %h, got %h",
                     $time, field, rsp_seen, want, got);
        end
    endtask

    task automatic check_response();
        queue_rsp_t want;
        rsp_seen++;
        if (pending_rsps.size() == 0) begin
            mismatches++;
            $display("%0t: response %0d: expected none, got status %0d, word %h",
                     $time, rsp_seen, rsp.status, rsp.out_word);
            return;
        end
        want = pending_rsps.pop_front();
        compare_field("status", bfq_pkg::WORD_W'(want.status),
                      bfq_pkg::WORD_W'(rsp.status));
        compare_field("out_word", want.out_word, rsp.out_word);
        compare_field("last_flag", bfq_pkg::WORD_W'(want.last),
                      bfq_pkg::WORD_W'(rsp.last_flag));
        compare_field("entry_count", bfq_pkg::WORD_W'(want.count),
                      bfq_pkg::WORD_W'(rsp.entry_count));
        compare_field("empty_flag", bfq_pkg::WORD_W'(want.empty),
                      bfq_pkg::WORD_W'(rsp.empty_flag));
        compare_field("full_flag", bfq_pkg::WORD_W'(want.full),
                      bfq_pkg::WORD_W'(rsp.full_flag));
        compare_field("front_word", want.front, rsp.front_word);
    endtask

    // Response checker
    always @(posedge clk)
        if (rst_n === 1'b1 && rsp.valid && rsp.ready)
            check_response();

    // Response side: alternate ready runs and stalls
    initial begin : rsp_sink
        int hold;
        hold = 0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
            end
            else if (rsp.ready) begin
                hold = pick_gap();
                if (hold > 0) begin
                    rsp.ready <= 1'b0;
                    hold--;
                end
            end
            else begin
                rsp.ready <= 1'b1;
                hold = $urandom_range(0, 8);
            end
        end
    end

    // Watchdog: no word moving on either side for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: timeout, no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        bfq_pkg::opcode_t           op;
        logic [bfq_pkg::WORD_W-1:0] w;
        int                         roll;
        int                         mode_left;
        bit                         filling;

        req.valid     = 1'b0;
        req.opcode    = bfq_pkg::OP_PUSH;
        req.push_word = '0;
        rst_n         = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        foreach (DIR_TABLE[i])
            send_request(DIR_TABLE[i].op, DIR_TABLE[i].word, DIR_TABLE[i].typed,
                         DIR_TABLE[i].rsp);

        // Random traffic, swinging between fill-heavy and drain-heavy stretches
        filling   = 1'b0;
        mode_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mode_left == 0) begin
                filling   = !filling;
                mode_left = $urandom_range(15, 40);
                steady    = ($urandom_range(0, 3) == 0);
            end
            mode_left--;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = bfq_pkg::OP_CLEAR;
            else if (roll < 14)
                op = bfq_pkg::OP_TRAVERSE;
            else if ((roll < 75) == filling)
                op = bfq_pkg::OP_PUSH;
            else
                op = bfq_pkg::OP_POP;
            case ($urandom_range(0, 7))
                0:       w = '0;
                1:       w = '1;
                default: w = $urandom;
            endcase
            send_request(op, w, 1'b0, RSP_NONE);
        end
        req.valid <= 1'b0;

        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d responses: %0d refused pushes, %0d refused pops,",
                 req_count, rsp_seen, full_refusals, empty_refusals);
        $display("longest traverse %0d words.", longest_trav);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
sv/bfq_pkg.sv
sv/bfq_if.sv
sv/bfq_dpath.sv
sv/bfq_ctrl.sv
sv/bounded_fifo_queue.sv
sim/bounded_fifo_queue_test.sv
